// ----- rtl/lbh_pkg.sv -----
// Shared types and constants for the LSH bucket hash block.
// Used by lbh_cell, lbh_post and lsh_bucket_hash; depends on nothing.
package lbh_pkg;

    localparam int H_W    = 50;
    localparam int G_W    = 56;
    localparam int ACC_W  = 64;
    localparam int TS_W   = 21;
    localparam int BKT_W  = 20;
    localparam int MAG_W  = 31;
    localparam int WIN_SHIFT = 14;

    localparam logic [MAG_W-1:0] ID_MOD = 31'h7FFF_FFFF;
    localparam logic [TS_W-1:0]  MAX_TS = 21'h10_0000;

    typedef enum logic [1:0] {
        OP_COEF  = 2'd0,
        OP_OFFS  = 2'd1,
        OP_COORD = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    localparam logic REG_TABLE_SIZE = 1'b0;
    localparam logic REG_R_WEIGHTS  = 1'b1;

    typedef enum logic [3:0] {
        P_IDLE,
        P_FIN,
        P_WAIT,
        P_SHIFT,
        P_ABS,
        P_FOLD1,
        P_FOLD2,
        P_FIX,
        P_DIV,
        P_OUT
    } post_state_t;

    typedef struct packed {
        logic fin;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic              v;
        logic [6:0]        ci;
        logic signed [31:0] x;
    } coord_t;

endpackage

// ----- rtl/lsh_bucket_hash.sv -----
// Top level of the Euclidean LSH bucket hash: input decode, cell chain, result sequencer.
// Depends on lbh_pkg, lbh_cell and lbh_post.
//
//  channel  direction  handshake          contents
//  s_       in         s_tvalid/s_tready  load or coordinate item
//  m_       out        m_tvalid/m_tready  one result per table
//  cfg_     in         cfg_wr_en          table_size, r_weights
//
// A load item is accepted without blocking the input. A coordinate item blocks the input
// while it travels down the chain of cells, one cell per cycle.
// After a final coordinate the input stays blocked while the result sequencer forms the
// results with the one-bit-per-cycle bucket divider. Reset is synchronous and active low.
// A stalled result holds in the output register; the sequencer waits on it.
module lsh_bucket_hash #(
    parameter int DIM             = 128,
    parameter int FUNCS_PER_TABLE = 4,
    parameter int TABLES          = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // table_sel[3:0], func_sel[6:4], coord_index[13:7], data_value[45:14]
    input  logic [1:0]  s_tuser,   // opcode
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // bucket_index[19:0], point_id[51:20]
    output logic [3:0]  m_tuser,   // table_id
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [20:0] cfg_wdata
);
    import lbh_pkg::*;

    localparam int NF  = TABLES * FUNCS_PER_TABLE;
    localparam int LAT = NF + 2;
    localparam int CW  = $clog2(LAT + 1);

    logic             accept;
    opcode_t          op;
    logic [3:0]       tsel;
    logic [2:0]       fsel;
    logic [6:0]       ci;
    logic [31:0]      data;
    logic             ci_ok;
    logic             is_coord;
    logic [CW-1:0]    cnt_reg;
    logic             pend_reg;
    logic             start;
    logic             post_busy;
    logic [TS_W-1:0]  ts_reg;
    logic [15:0]      rw_reg;
    cell_ctrl_t       ctrl;
    coord_t           chain [NF+1];
    logic signed [H_W-1:0] h_chain [NF+1];

    assign accept   = s_tvalid && s_tready;
    assign op       = opcode_t'(s_tuser);
    assign tsel     = s_tdata[3:0];
    assign fsel     = s_tdata[6:4];
    assign ci       = s_tdata[13:7];
    assign data     = s_tdata[45:14];
    assign ci_ok    = {1'b0, ci} < 8'(DIM);
    assign is_coord = accept && op == OP_COORD;
    assign start    = pend_reg && cnt_reg == '0;
    assign s_tready = cnt_reg == '0 && !pend_reg && !post_busy;

    assign chain[0].v  = is_coord && ci_ok;
    assign chain[0].ci = ci;
    assign chain[0].x  = data;
    assign h_chain[NF] = '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
            ts_reg   <= TS_W'(1);
            rw_reg   <= '0;
        end else begin
            if (is_coord) begin
                cnt_reg <= CW'(LAT);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (is_coord && s_tlast) begin
                pend_reg <= 1'b1;
            end else if (start) begin
                pend_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_TABLE_SIZE: ts_reg <= cfg_wdata;
                    REG_R_WEIGHTS:  rw_reg <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
        end
    end

    for (genvar k = 0; k < NF; k++) begin : g_cell
        logic sel;
        assign sel = accept && tsel == 4'(k / FUNCS_PER_TABLE)
                     && fsel == 3'(k % FUNCS_PER_TABLE);
        lbh_cell #(.DIM(DIM)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .coef_we   (sel && op == OP_COEF && ci_ok),
            .offs_we   (sel && op == OP_OFFS),
            .load_ci   (ci),
            .load_data (data),
            .c_in      (chain[k]),
            .c_out     (chain[k+1]),
            .h_in      (h_chain[k+1]),
            .h_out     (h_chain[k])
        );
    end

    lbh_post #(.TABLES(TABLES), .FUNCS_PER_TABLE(FUNCS_PER_TABLE)) u_post (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start),
        .table_size (ts_reg),
        .r_weights  (rw_reg),
        .h_head     (h_chain[0]),
        .ctrl       (ctrl),
        .busy       (post_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    a_no_accept_while_post: assert property (@(posedge aclk) disable iff (!aresetn)
        post_busy |-> !s_tready) else $error("item accepted while results are formed");

    a_coord_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        is_coord |=> !s_tready) else $error("item accepted while a coordinate is in flight");

    a_fin_after_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.fin |-> cnt_reg == '0) else $error("finalize while the chain is busy");

endmodule

// ----- rtl/lbh_ram.sv -----
// Generic single-write, single-read memory with registered read data.
// Standalone; no package needed.
module lbh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/lbh_cell.sv -----
// One hash function cell: coefficient memory, multiply-accumulate, offset and window.
// Depends on lbh_pkg and lbh_ram.
module lbh_cell #(
    parameter int DIM = 128
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lbh_pkg::cell_ctrl_t         ctrl,
    input  logic                        coef_we,
    input  logic                        offs_we,
    input  logic [6:0]                  load_ci,
    input  logic [31:0]                 load_data,
    input  lbh_pkg::coord_t             c_in,
    output lbh_pkg::coord_t             c_out,
    input  logic signed [lbh_pkg::H_W-1:0] h_in,
    output logic signed [lbh_pkg::H_W-1:0] h_out
);
    import lbh_pkg::*;

    localparam int AW = DIM > 1 ? $clog2(DIM) : 1;

    coord_t              c_reg;
    logic [15:0]         coef;
    logic                mul_v_reg;
    logic signed [47:0]  prod_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [31:0]         offs_reg;
    logic [ACC_W-1:0]    s_reg;
    logic [ACC_W-1:0]    s_adj;
    logic                fin_d_reg;
    logic signed [H_W-1:0] h_reg;

    lbh_ram #(.WIDTH(16), .DEPTH(DIM)) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (load_ci[AW-1:0]),
        .wdata (load_data[15:0]),
        .raddr (c_in.ci[AW-1:0]),
        .rdata (coef)
    );

    assign s_adj = s_reg + (s_reg[ACC_W-1] ? ACC_W'((1 << WIN_SHIFT) - 1) : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_reg.v   <= 1'b0;
            mul_v_reg <= 1'b0;
            fin_d_reg <= 1'b0;
            acc_reg   <= '0;
        end else begin
            c_reg.v   <= c_in.v;
            mul_v_reg <= c_reg.v;
            fin_d_reg <= ctrl.fin;
            if (ctrl.fin) begin
                acc_reg <= '0;
            end else if (mul_v_reg) begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
        c_reg.ci <= c_in.ci;
        c_reg.x  <= c_in.x;
        prod_reg <= $signed(c_reg.x) * $signed(coef);
        if (offs_we) begin
            offs_reg <= load_data;
        end
        if (ctrl.fin) begin
            s_reg <= acc_reg + {{(ACC_W-32){offs_reg[31]}}, offs_reg};
        end
        if (fin_d_reg) begin
            h_reg <= $signed(s_adj[ACC_W-1:WIN_SHIFT]);
        end else if (ctrl.shift) begin
            h_reg <= h_in;
        end
    end

    assign c_out = c_reg;
    assign h_out = h_reg;

endmodule

// ----- rtl/lbh_post.sv -----
// Result sequencer: weighted sum per table, Mersenne reduction, bucket divider.
// Depends on lbh_pkg; owns the result output register.
module lbh_post #(
    parameter int TABLES          = 5,
    parameter int FUNCS_PER_TABLE = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [lbh_pkg::TS_W-1:0]    table_size,
    input  logic [15:0]                 r_weights,
    input  logic signed [lbh_pkg::H_W-1:0] h_head,
    output lbh_pkg::cell_ctrl_t         ctrl,
    output logic                        busy,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [55:0]                 m_tdata,
    output logic [3:0]                  m_tuser,
    output logic                        m_tlast
);
    import lbh_pkg::*;

    localparam int FW = FUNCS_PER_TABLE > 1 ? $clog2(FUNCS_PER_TABLE) : 1;

    post_state_t             state_reg, state_next;
    logic [FW-1:0]           f_reg, f_next;
    logic [3:0]              t_reg, t_next;
    logic [G_W-1:0]          g_reg, g_next;
    logic                    neg_reg, neg_next;
    logic [MAG_W+1:0]        mag_reg, mag_next;
    logic [MAG_W-1:0]        dvd_reg, dvd_next;
    logic [TS_W-1:0]         rem_reg, rem_next;
    logic [4:0]              cnt_reg, cnt_next;
    logic                    vld_reg, vld_next;
    logic [55:0]             data_reg, data_next;
    logic [3:0]              user_reg, user_next;
    logic                    last_reg, last_next;

    logic [TS_W-1:0]         ts_eff;
    logic [1:0]              r_w;
    logic signed [H_W+1:0]   rh;
    logic [TS_W:0]           trial;
    logic [TS_W-1:0]         bucket;
    logic [31:0]             id_val;

    assign ts_eff = (table_size == '0) ? TS_W'(1) :
                    (table_size > MAX_TS) ? MAX_TS : table_size;
    assign r_w    = r_weights[2*f_reg +: 2];
    assign rh     = h_head * $signed({1'b0, r_w});
    assign trial  = {rem_reg, dvd_reg[MAG_W-1]};
    assign bucket = (neg_reg && rem_reg != '0) ? ts_eff - rem_reg : rem_reg;
    assign id_val = neg_reg ? 32'(-{1'b0, mag_reg[MAG_W-1:0]}) : {1'b0, mag_reg[MAG_W-1:0]};

    always_comb begin
        state_next = state_reg;
        f_next     = f_reg;
        t_next     = t_reg;
        g_next     = g_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        vld_next   = vld_reg && !m_tready;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        ctrl       = '0;
        unique case (state_reg)
            P_IDLE: begin
                if (start) begin
                    state_next = P_FIN;
                    f_next     = '0;
                    t_next     = '0;
                    g_next     = '0;
                end
            end
            P_FIN: begin
                ctrl.fin   = 1'b1;
                state_next = P_WAIT;
            end
            P_WAIT: begin
                state_next = P_SHIFT;
            end
            P_SHIFT: begin
                ctrl.shift = 1'b1;
                g_next     = g_reg + G_W'(rh);
                if (f_reg == FW'(FUNCS_PER_TABLE - 1)) begin
                    f_next     = '0;
                    state_next = P_ABS;
                end else begin
                    f_next = f_reg + 1'b1;
                end
            end
            P_ABS: begin
                neg_next   = g_reg[G_W-1];
                g_next     = g_reg[G_W-1] ? -g_reg : g_reg;
                state_next = P_FOLD1;
            end
            P_FOLD1: begin
                mag_next   = (MAG_W+2)'(g_reg[MAG_W-1:0]) + (MAG_W+2)'(g_reg[G_W-1:MAG_W]);
                state_next = P_FOLD2;
            end
            P_FOLD2: begin
                mag_next   = (MAG_W+2)'(mag_reg[MAG_W-1:0]) + (MAG_W+2)'(mag_reg[MAG_W+1:MAG_W]);
                state_next = P_FIX;
            end
            P_FIX: begin
                if (mag_reg >= (MAG_W+2)'(ID_MOD)) begin
                    mag_next = mag_reg - (MAG_W+2)'(ID_MOD);
                    dvd_next = MAG_W'(mag_reg - (MAG_W+2)'(ID_MOD));
                end else begin
                    dvd_next = mag_reg[MAG_W-1:0];
                end
                rem_next   = '0;
                cnt_next   = 5'(MAG_W - 1);
                state_next = P_DIV;
            end
            P_DIV: begin
                if (trial >= {1'b0, ts_eff}) begin
                    rem_next = TS_W'(trial - {1'b0, ts_eff});
                end else begin
                    rem_next = trial[TS_W-1:0];
                end
                dvd_next = {dvd_reg[MAG_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = P_OUT;
                end
            end
            P_OUT: begin
                if (!vld_reg || m_tready) begin
                    vld_next  = 1'b1;
                    data_next = {4'b0, id_val, bucket[BKT_W-1:0]};
                    user_next = t_reg;
                    last_next = (t_reg == 4'(TABLES - 1));
                    g_next    = '0;
                    if (t_reg == 4'(TABLES - 1)) begin
                        state_next = P_IDLE;
                    end else begin
                        t_next     = t_reg + 1'b1;
                        state_next = P_SHIFT;
                    end
                end
            end
            default: begin
                state_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= P_IDLE;
            vld_reg   <= 1'b0;
            f_reg     <= '0;
            t_reg     <= '0;
        end else begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
            f_reg     <= f_next;
            t_reg     <= t_next;
        end
        g_reg    <= g_next;
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign busy     = (state_reg != P_IDLE);
    assign m_tvalid = vld_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule
